>>> design/fvi_pkg.sv
package fvi_pkg;

    localparam int MAX_IMAGE_BYTES = 262144;
    // count saturates at MAX_IMAGE_BYTES + 1
    localparam int CNT_W   = $clog2(MAX_IMAGE_BYTES + 2);
    localparam int SIZE_W  = 19;
    localparam int CMP_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int POS_W   = 4;
    localparam int HEADER_BYTES = 8;
    localparam int TRAILER_BYTES = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] MIN_SIZE_RST   = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST   = SIZE_W'(262144);
    localparam logic [31:0]       STACK_LOW_RST  = 32'h20000000;
    localparam logic [31:0]       STACK_HIGH_RST = 32'h20008000;
    localparam logic [7:0]        CODE_REGION_RST = 8'h08;

    typedef enum logic [2:0] {
        REG_MIN_SIZE    = 3'd0,
        REG_MAX_SIZE    = 3'd1,
        REG_STACK_LOW   = 3'd2,
        REG_STACK_HIGH  = 3'd3,
        REG_CODE_REGION = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_SIZE   = 2'd1,
        FAULT_STACK  = 2'd2,
        FAULT_VECTOR = 2'd3
    } fault_t;

    typedef struct packed {
        logic [SIZE_W-1:0] min_size;
        logic [SIZE_W-1:0] max_size;
        logic [31:0]       stack_low;
        logic [31:0]       stack_high;
        logic [7:0]        code_region;
    } cfg_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;       // byte index, clamped at HEADER_BYTES
        logic             size_bad;  // only meaningful with last
    } qentry_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/fvi_front.sv
module fvi_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       image_byte,
    input  logic             final_byte,
    input  fvi_pkg::cfg_t    cfg,
    input  logic             q_full,
    output logic             q_push,
    output fvi_pkg::qentry_t q_entry
);

    localparam logic [fvi_pkg::CNT_W-1:0] CNT_SAT =
        fvi_pkg::CNT_W'(fvi_pkg::MAX_IMAGE_BYTES + 1);
    localparam logic [fvi_pkg::CNT_W-1:0] CNT_HDR = fvi_pkg::CNT_W'(fvi_pkg::HEADER_BYTES);

    logic [fvi_pkg::CNT_W-1:0] cnt_reg;
    logic [fvi_pkg::CNT_W-1:0] cnt_next;
    logic [fvi_pkg::CMP_W-1:0] size_x;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign cnt_next = (cnt_reg < CNT_SAT) ? cnt_reg + fvi_pkg::CNT_W'(1) : cnt_reg;
    assign size_x   = fvi_pkg::CMP_W'(cnt_next);

    always_comb
    begin
        q_entry.data = image_byte;
        q_entry.last = final_byte;
        q_entry.pos  = (cnt_reg >= CNT_HDR) ? fvi_pkg::POS_W'(fvi_pkg::HEADER_BYTES)
                                            : cnt_reg[fvi_pkg::POS_W-1:0];
        q_entry.size_bad = (size_x < fvi_pkg::CMP_W'(fvi_pkg::HEADER_BYTES))
                        || (size_x < fvi_pkg::CMP_W'(cfg.min_size))
                        || (size_x > fvi_pkg::CMP_W'(cfg.max_size))
                        || (size_x > fvi_pkg::CMP_W'(fvi_pkg::MAX_IMAGE_BYTES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (q_push)
        begin
            cnt_reg <= final_byte ? '0 : cnt_next;
        end
    end

endmodule

>>> design/fvi_queue.sv
module fvi_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fvi_pkg::qentry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output fvi_pkg::qentry_t head_entry
);

    fvi_pkg::qentry_t           slot_reg [fvi_pkg::QUEUE_DEPTH];
    logic [fvi_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fvi_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fvi_pkg::QCNT_W-1:0] cnt_reg;
    logic [fvi_pkg::QCNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == fvi_pkg::QCNT_W'(fvi_pkg::QUEUE_DEPTH));
    assign not_empty  = (cnt_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + fvi_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - fvi_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + fvi_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + fvi_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> design/fvi_back.sv
module fvi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  fvi_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  fvi_pkg::qentry_t q_entry,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             image_ok,
    output logic [1:0]       fault_code,
    output logic             crc_matches,
    output logic [31:0]      computed_crc
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] tail_reg, tail_next;
    logic [31:0] stack_reg, stack_next;
    logic [31:0] vector_reg, vector_next;
    logic [31:0] result_crc;
    fvi_pkg::fault_t fault;

    logic        out_valid_reg;
    logic        ok_reg;
    logic [1:0]  fault_reg;
    logic        match_reg;
    logic [31:0] crc_out_reg;

    // non-final bytes never wait on the result register
    assign q_pop = q_valid && (!q_entry.last || !out_valid_reg || !out_stall);

    always_comb
    begin
        crc_next    = (q_entry.pos >= fvi_pkg::POS_W'(fvi_pkg::TRAILER_BYTES))
                    ? fvi_pkg::crc_byte(crc_reg, tail_reg[7:0]) : crc_reg;
        tail_next   = {q_entry.data, tail_reg[31:8]};
        stack_next  = stack_reg;
        vector_next = vector_reg;
        if (q_entry.pos < fvi_pkg::POS_W'(4))
            stack_next[8*q_entry.pos[1:0] +: 8] = stack_reg[8*q_entry.pos[1:0] +: 8]
                                                 | q_entry.data;
        else if (q_entry.pos < fvi_pkg::POS_W'(fvi_pkg::HEADER_BYTES))
            vector_next[8*q_entry.pos[1:0] +: 8] = vector_reg[8*q_entry.pos[1:0] +: 8]
                                                  | q_entry.data;

        result_crc = ~crc_next;

        if (q_entry.size_bad)
            fault = fvi_pkg::FAULT_SIZE;
        else if (stack_next < cfg.stack_low || stack_next > cfg.stack_high)
            fault = fvi_pkg::FAULT_STACK;
        else if (vector_next[31:24] != cfg.code_region || !vector_next[0])
            fault = fvi_pkg::FAULT_VECTOR;
        else
            fault = fvi_pkg::FAULT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= fvi_pkg::CRC_INIT;
            tail_reg      <= '0;
            stack_reg     <= '0;
            vector_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_entry.last)
                begin
                    crc_reg    <= fvi_pkg::CRC_INIT;
                    tail_reg   <= '0;
                    stack_reg  <= '0;
                    vector_reg <= '0;
                end
                else
                begin
                    crc_reg    <= crc_next;
                    tail_reg   <= tail_next;
                    stack_reg  <= stack_next;
                    vector_reg <= vector_next;
                end
            end
            if (q_pop && q_entry.last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_entry.last)
        begin
            ok_reg      <= (fault == fvi_pkg::FAULT_NONE);
            fault_reg   <= fault;
            match_reg   <= (result_crc == tail_next);
            crc_out_reg <= result_crc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign image_ok     = ok_reg;
    assign fault_code   = fault_reg;
    assign crc_matches  = match_reg;
    assign computed_crc = crc_out_reg;

endmodule

>>> design/firmware_image_validator_core.sv
// Firmware image validator.
// Input channel: one image byte per transfer (image_byte), final_byte set on
// the last byte of an image. Output channel: one transfer per image carrying
// image_ok, fault_code (first failing of size, stack pointer, reset vector),
// computed_crc (reflected CRC-32 over all but the last four bytes) and
// crc_matches (computed_crc equals the little-endian trailer).
// Throughput: one byte per cycle sustained while in_stall is low. The front counts
// and classifies bytes and checks the size; a 4-entry queue feeds the back,
// which runs the 8-bit CRC update and the stack pointer and reset vector checks.
// The result is valid once the final byte has passed through a queue slot and the
// back's output register.
// When the receiver stalls, the result holds in its output register; the back
// keeps draining non-final bytes, and the input stalls only once the queue
// fills behind a second final byte.
// Reset clears all image state and loads the default configuration; image
// state also returns to its reset value after every image.
// Config: APB, pready always high, registers at byte address 4*index.
module firmware_image_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  image_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        image_ok,
    output logic [1:0]  fault_code,
    output logic        crc_matches,
    output logic [31:0] computed_crc
);

    fvi_pkg::cfg_t      cfg_reg;
    fvi_pkg::reg_index_t reg_sel;
    logic               wr_en;

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    fvi_pkg::qentry_t   push_entry;
    fvi_pkg::qentry_t   head_entry;

    assign pready  = 1'b1;
    assign reg_sel = fvi_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_size    <= fvi_pkg::MIN_SIZE_RST;
            cfg_reg.max_size    <= fvi_pkg::MAX_SIZE_RST;
            cfg_reg.stack_low   <= fvi_pkg::STACK_LOW_RST;
            cfg_reg.stack_high  <= fvi_pkg::STACK_HIGH_RST;
            cfg_reg.code_region <= fvi_pkg::CODE_REGION_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                fvi_pkg::REG_MIN_SIZE:    cfg_reg.min_size    <= pwdata[fvi_pkg::SIZE_W-1:0];
                fvi_pkg::REG_MAX_SIZE:    cfg_reg.max_size    <= pwdata[fvi_pkg::SIZE_W-1:0];
                fvi_pkg::REG_STACK_LOW:   cfg_reg.stack_low   <= pwdata;
                fvi_pkg::REG_STACK_HIGH:  cfg_reg.stack_high  <= pwdata;
                fvi_pkg::REG_CODE_REGION: cfg_reg.code_region <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fvi_pkg::REG_MIN_SIZE:    prdata = 32'(cfg_reg.min_size);
            fvi_pkg::REG_MAX_SIZE:    prdata = 32'(cfg_reg.max_size);
            fvi_pkg::REG_STACK_LOW:   prdata = cfg_reg.stack_low;
            fvi_pkg::REG_STACK_HIGH:  prdata = cfg_reg.stack_high;
            fvi_pkg::REG_CODE_REGION: prdata = 32'(cfg_reg.code_region);
            default:                  prdata = '0;
        endcase
    end

    fvi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .image_byte (image_byte),
        .final_byte (final_byte),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    fvi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head_entry (head_entry)
    );

    fvi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_entry      (head_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .image_ok     (image_ok),
        .fault_code   (fault_code),
        .crc_matches  (crc_matches),
        .computed_crc (computed_crc)
    );

endmodule
